// ===== hdl/ssmc_pkg.sv =====
// ---------------------------------------------------------------------------
// ssmc_pkg
// Shared types and constants for the minimum-count subset-sum block.
// ---------------------------------------------------------------------------
`default_nettype none

package ssmc_pkg;

  // Row geometry and count coding.
  localparam int MAX_SUM    = 1023;
  localparam int ROW_DEPTH  = MAX_SUM + 1;
  localparam int ADDR_BITS  = $clog2(ROW_DEPTH);
  localparam int COUNT_BITS = 8;

  localparam logic [COUNT_BITS-1:0] CNT_NONE = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_TOP  = CNT_NONE - 1'b1;

  // Register indexes of the configuration port.
  localparam logic CFG_TARGET_SUM  = 1'b0;
  localparam logic CFG_COUNT_LIMIT = 1'b1;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  // One input transaction.
  typedef struct packed {
    logic [9:0] item_value;
    logic       last_item;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic       feasible;
    logic [7:0] min_count;
  } result_t;

  // Access request from the controller to the row memory.
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    cnt_t  wr_data;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_TGT_RD,
    ST_REPORT,
    ST_CLEAR
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/ssmc_row_ram.sv =====
// ---------------------------------------------------------------------------
// ssmc_row_ram
// Synchronous RAM with one write port and two registered read ports.
// ---------------------------------------------------------------------------
`default_nettype none

module ssmc_row_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr_a,
  input  wire logic [AW-1:0] rd_addr_b,
  output logic      [DW-1:0] rd_data_a,
  output logic      [DW-1:0] rd_data_b
);

  logic [DW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two read ports, both registered.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ===== hdl/ssmc_ctrl.sv =====
// ---------------------------------------------------------------------------
// ssmc_ctrl
// Row walk sequencer: read-modify-write of the count row, result, clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module ssmc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire ssmc_pkg::item_t   item,
  input  wire logic [9:0]        target_sum,
  input  wire logic [7:0]        count_limit,
  input  wire ssmc_pkg::cnt_t    rd_data_a,
  input  wire ssmc_pkg::cnt_t    rd_data_b,
  output ssmc_pkg::mem_req_t     mem_req,
  output logic                   busy,
  output logic                   done,
  output ssmc_pkg::result_t      result
);

  import ssmc_pkg::*;

  state_t  state;
  state_t  state_next;
  addr_t   walk_index;
  addr_t   value;
  logic    last;
  logic    p_valid;
  addr_t   p_addr;
  addr_t   clr_index;
  cnt_t    cand;
  logic    upd;
  logic    value_ok;
  logic    walk_end;
  logic    tgt_out;
  cnt_t    tgt_cnt;

  // An item of value zero or beyond the row leaves the row alone.
  assign value_ok = (item.item_value != 10'd0) && (32'(item.item_value) <= MAX_SUM);
  assign walk_end = (walk_index == value);
  assign tgt_out  = (32'(target_sum) > MAX_SUM);

  // Candidate count from the entry one item below, saturated.
  always_comb begin
    if (rd_data_b >= CNT_TOP) begin
      cand = CNT_TOP;
    end else begin
      cand = rd_data_b + 1'b1;
    end
    upd = p_valid && (rd_data_b != CNT_NONE) && (cand < rd_data_a);
  end

  // Count at the target, or the unreachable code if the target is off the row.
  assign tgt_cnt = tgt_out ? CNT_NONE : rd_data_a;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (value_ok) begin
            state_next = ST_WALK;
          end else if (item.last_item) begin
            state_next = ST_TGT_RD;
          end
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = last ? ST_TGT_RD : ST_IDLE;
      end
      ST_TGT_RD: begin
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        state_next = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (32'(clr_index) == MAX_SUM) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Memory requests and handshake outputs.
  always_comb begin
    busy              = (state != ST_IDLE);
    mem_req.rd_addr_a = walk_index;
    mem_req.rd_addr_b = walk_index - value;
    mem_req.wr_en     = upd;
    mem_req.wr_addr   = p_addr;
    mem_req.wr_data   = cand;
    case (state)
      ST_TGT_RD: begin
        mem_req.rd_addr_a = ADDR_BITS'(target_sum);
      end
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_index;
        mem_req.wr_data = (clr_index == '0) ? '0 : CNT_NONE;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      walk_index <= '0;
      clr_index  <= '0;
      p_valid    <= 1'b0;
      done       <= 1'b0;
      last       <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= (state == ST_WALK);
      done    <= (state == ST_REPORT);
      case (state)
        ST_IDLE: begin
          if (start) begin
            last       <= item.last_item;
            walk_index <= ADDR_BITS'(MAX_SUM);
          end
        end
        ST_WALK: begin
          walk_index <= walk_end ? '0 : walk_index - 1'b1;
        end
        ST_REPORT: begin
          clr_index <= '0;
        end
        ST_CLEAR: begin
          clr_index <= clr_index + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    p_addr <= walk_index;
    if (state == ST_IDLE && start) begin
      value <= ADDR_BITS'(item.item_value);
    end
    if (state == ST_REPORT) begin
      result.min_count <= 8'(tgt_cnt);
      result.feasible  <= (tgt_cnt != CNT_NONE) && (32'(tgt_cnt) <= 32'(count_limit));
    end
  end

endmodule

`default_nettype wire

// ===== hdl/subset_sum_min_count.sv =====
// ---------------------------------------------------------------------------
// subset_sum_min_count
// Minimum item count for an exact subset sum, one item transaction at a time.
// ---------------------------------------------------------------------------
//   Channel   Ports                              Handshake
//   item      start, item, busy                  taken when start && !busy
//   result    done, result                       one-cycle strobe, no stall
//   config    cfg_we, cfg_index, cfg_data        written when cfg_we is high
//
// An item of value v walks the row from the top sum down to v, one entry per
// cycle through the two-read, one-write row memory, then a write-back state
// (ST_DRAIN); busy is high through both, and the next item waits for idle.
// A zero-value item that is not the last keeps busy low. The last item then
// reads the target (ST_TGT_RD), reports (ST_REPORT) and runs a clearing pass
// over MAX_SUM + 1 entries (1024) with busy high; done pulses as it begins.
// Reset starts the same clearing pass. Results cannot be held off.
// ---------------------------------------------------------------------------
`default_nettype none

module subset_sum_min_count (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire ssmc_pkg::item_t   item,
  output logic                   busy,
  output logic                   done,
  output ssmc_pkg::result_t      result,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [9:0]        cfg_data
);

  import ssmc_pkg::*;

  logic [9:0] target_sum;
  logic [7:0] count_limit;
  mem_req_t   mem_req;
  cnt_t       rd_data_a;
  cnt_t       rd_data_b;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum  <= '0;
      count_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_SUM:  target_sum  <= cfg_data;
        CFG_COUNT_LIMIT: count_limit <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  ssmc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .target_sum  (target_sum),
    .count_limit (count_limit),
    .rd_data_a   (rd_data_a),
    .rd_data_b   (rd_data_b),
    .mem_req     (mem_req),
    .busy        (busy),
    .done        (done),
    .result      (result)
  );

  ssmc_row_ram #(
    .DEPTH (ROW_DEPTH),
    .AW    (ADDR_BITS),
    .DW    (COUNT_BITS)
  ) u_row_ram (
    .clk       (clk),
    .wr_en     (mem_req.wr_en),
    .wr_addr   (mem_req.wr_addr),
    .wr_data   (mem_req.wr_data),
    .rd_addr_a (mem_req.rd_addr_a),
    .rd_addr_b (mem_req.rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule

`default_nettype wire
